/* design/afu_pkg.sv */
// Shared types, constants and the sigmoid sample generator for the activation unit.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package afu_pkg;

  // Default table and number format
  localparam int TABLE_SEGMENTS = 256;
  localparam int FRAC_BITS      = 10;

  localparam int DATA_W     = 16;
  localparam int OP_W       = 3;
  // register stages from input beat to output register
  localparam int PIPE_DEPTH = 7;

  typedef enum logic [OP_W-1:0] {
    OP_SIG    = 3'd0,
    OP_SIG_D  = 3'd1,
    OP_RELU   = 3'd2,
    OP_RELU_D = 3'd3,
    OP_TANH   = 3'd4,
    OP_TANH_D = 3'd5
  } op_e;

  // Unsigned 64-bit quotient by shift and subtract, elaboration time only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          bt;
    rem = '0;
    quo = '0;
    for (bt = 63; bt >= 0; bt--) begin
      rem = {rem[63:0], num[bt]};
      if (rem >= {1'b0, den}) begin
        rem     = rem - {1'b0, den};
        quo[bt] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sample idx of 2^frac_bits * sigmoid(-8 + 16*idx/segs), elaboration time only.
  // exp(-16/segs) by its power series in Q58, then repeated Q58 products.
  function automatic logic [15:0] sig_sample(input int idx, input int segs,
                                             input int frac_bits);
    logic [63:0]  one58;
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  dv;
    logic [63:0]  r;
    logic [63:0]  q;
    logic [63:0]  qs;
    logic [63:0]  ds;
    logic [63:0]  num;
    logic [63:0]  v;
    logic [127:0] prod;
    int           half;
    int           n;
    int           k;
    int           j;
    one58 = 64'd1 << 58;
    term  = one58;
    pos   = one58;
    neg   = 64'd0;
    for (k = 1; k <= 30; k++) begin
      dv   = 64'(segs) * 64'(k);
      term = udiv64(term * 64'd16, dv);
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    r    = pos - neg;
    half = segs / 2;
    n    = (idx >= half) ? (idx - half) : (half - idx);
    q    = one58;
    for (j = 0; j < n; j++) begin
      prod = {64'd0, q} * {64'd0, r};
      q    = prod[121:58];
    end
    qs  = q >> 20;
    ds  = (one58 + q) >> 20;
    num = qs << frac_bits;
    dv  = 64'd2 * ds;
    v   = udiv64(64'd2 * num + ds, dv);
    if (idx >= half) begin
      v = (64'd1 << frac_bits) - v;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

/* design/activation_function_unit_core.sv */
// Top level of the activation unit: pipeline valid/stall control, simple ops, final select.
// Depends on afu_pkg, afu_sig_pipe and afu_deriv_pipe.
//
//   channel | direction | valid       | stall        | payload
//   --------+-----------+-------------+--------------+----------------------------
//   in      | beat in   | in_valid_i  | in_stall_o   | opcode_i, operand_i
//   out     | beat out  | out_valid_o | out_stall_i  | result_o, saturated_o
//
// One beat per cycle sustained while out_stall_i stays low; each beat passes seven register
// stages, the last being the output register, a depth set by the sigmoid path (split,
// table read, interpolation multiply, reciprocal divide).
// Reset clears the stage valid bits only; the sample table is constant logic.
// A stage loads when it is empty or its successor loads, so bubbles close up;
// in_stall_o rises only when all stages hold beats and out_stall_i is high.
`default_nettype none

module activation_function_unit_core #(
  parameter int TABLE_SEGMENTS = afu_pkg::TABLE_SEGMENTS,
  parameter int FRAC_BITS      = afu_pkg::FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [afu_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [afu_pkg::DATA_W-1:0] operand_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [afu_pkg::DATA_W-1:0]      result_o,
  output logic                                   saturated_o
);

  localparam int ND    = afu_pkg::PIPE_DEPTH;
  localparam int SW    = FRAC_BITS + 1;
  localparam int ONE_V = 1 << FRAC_BITS;

  localparam logic [15:0] ONE_16 = 16'(ONE_V);
  localparam logic [16:0] ONE_17 = 17'(ONE_V);

  // per-beat side data carried alongside the arithmetic paths
  typedef struct packed {
    logic [afu_pkg::OP_W-1:0] op;
    logic [15:0]              simple;  // ReLU, ReLU derivative, unused codes
  } meta_t;

  // ---------------------------------------------------------------------------
  // Stage control: vld_q[k] belongs to stage k+1, load[k] loads it.
  // ---------------------------------------------------------------------------
  logic [ND-1:0] vld_q;
  logic [ND-1:0] load;

  always_comb begin
    load[ND-1] = ~vld_q[ND-1] | ~out_stall_i;
    for (int k = ND - 2; k >= 0; k--) begin
      load[k] = ~vld_q[k] | load[k+1];
    end
  end

  assign in_stall_o  = ~load[0];
  assign out_valid_o = vld_q[ND-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (load[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < ND; k++) begin
        if (load[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Simple ops are settled on entry and ride along with the op code.
  // ---------------------------------------------------------------------------
  meta_t meta_d;
  meta_t meta_q [ND-1];

  always_comb begin
    meta_d.op     = opcode_i;
    meta_d.simple = '0;
    case (opcode_i)
      afu_pkg::OP_RELU:   meta_d.simple = (operand_i > 16'sd0) ? operand_i : '0;
      afu_pkg::OP_RELU_D: meta_d.simple = (operand_i > 16'sd0) ? ONE_16 : '0;
      default:            meta_d.simple = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      meta_q[0] <= meta_d;
    end
    for (int k = 1; k < ND - 1; k++) begin
      if (load[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic paths, stages 1..6
  // ---------------------------------------------------------------------------
  logic [SW-1:0]      sig;
  logic signed [15:0] drv_res;
  logic               drv_sat;

  afu_sig_pipe #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_sig (
    .clk_i     (clk_i),
    .load_i    (load[ND-2:0]),
    .opcode_i  (opcode_i),
    .operand_i (operand_i),
    .sig_o     (sig)
  );

  afu_deriv_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_deriv (
    .clk_i     (clk_i),
    .load_i    (load[ND-2:0]),
    .opcode_i  (opcode_i),
    .operand_i (operand_i),
    .res_o     (drv_res),
    .sat_o     (drv_sat)
  );

  // ---------------------------------------------------------------------------
  // Stage 7: final select into the output register.
  // tanh = 2*sigmoid(2x) - 1 never leaves [-1, 1], so 17 bits cover the sum.
  // ---------------------------------------------------------------------------
  logic [16:0]              tanh_w;
  logic [15:0]              res_d;
  logic                     sat_d;
  logic [15:0]              res_q;
  logic                     sat_q;
  logic [afu_pkg::OP_W-1:0] op_q;

  assign tanh_w = (17'(sig) << 1) - ONE_17;

  always_comb begin
    res_d = meta_q[ND-2].simple;
    sat_d = 1'b0;
    unique case (meta_q[ND-2].op)
      afu_pkg::OP_SIG:  res_d = 16'(sig);
      afu_pkg::OP_TANH: res_d = tanh_w[15:0];
      afu_pkg::OP_SIG_D,
      afu_pkg::OP_TANH_D: begin
        res_d = drv_res;
        sat_d = drv_sat;
      end
      default: begin
        res_d = meta_q[ND-2].simple;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load[ND-1]) begin
      res_q <= res_d;
      sat_q <= sat_d;
      op_q  <= meta_q[ND-2].op;
    end
  end

  assign result_o    = res_q;
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // a free output side can always take the input beat
  a_free_out_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output side is free");

  // input is held back only with every stage occupied
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // sigmoid stays within [0, 1] and never clips
  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (op_q == afu_pkg::OP_SIG)) |->
      (result_o >= 16'sd0) && (res_q <= ONE_16) && !saturated_o)
    else $error("sigmoid result out of range");

  // a clipped result sits on one of the two rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (res_q == 16'h7fff) || (res_q == 16'h8000))
    else $error("saturation flag without a rail value");

endmodule

`default_nettype wire

/* design/afu_sig_pipe.sv */
// Sigmoid datapath: range check, segment split, sample table, interpolation.
// Uses afu_pkg (op codes, sample generator); stage loads come from the top level.
`default_nettype none

module afu_sig_pipe #(
  parameter int TABLE_SEGMENTS = afu_pkg::TABLE_SEGMENTS,
  parameter int FRAC_BITS      = afu_pkg::FRAC_BITS,
  localparam int SW            = FRAC_BITS + 1
) (
  input  wire logic                            clk_i,
  input  wire logic [afu_pkg::PIPE_DEPTH-2:0]  load_i,
  input  wire logic [afu_pkg::OP_W-1:0]        opcode_i,
  input  wire logic signed [afu_pkg::DATA_W-1:0] operand_i,
  output logic [SW-1:0]                        sig_o
);

  localparam int ONE_V   = 1 << FRAC_BITS;
  localparam int HALF_V  = 8 * ONE_V;
  localparam int AW      = (FRAC_BITS + 5 > 17) ? FRAC_BITS + 5 : 17;
  localparam int DW      = FRAC_BITS + 4;
  localparam int SEG_W   = (16 * ONE_V) / TABLE_SEGMENTS;
  localparam int FW      = $clog2(SEG_W);
  localparam int IDX_MAX = ((1 << DW) - 1) / SEG_W;
  localparam int IW      = $clog2(IDX_MAX + 1);
  localparam int RW      = $clog2(TABLE_SEGMENTS + 1);
  // exact floor division by SEG_W: multiply by ceil(2^K / SEG_W), keep bits above K
  localparam int K1      = DW + FW;
  localparam int M1W     = DW + 1;
  localparam int P1W     = DW + M1W;
  localparam longint unsigned M1 = ((64'd1 << K1) + 64'(SEG_W) - 64'd1) / SEG_W;
  localparam int NW      = SW + FW;
  localparam int K2      = NW + FW;
  localparam int M2W     = NW + 1;
  localparam int P2W     = NW + M2W;
  localparam longint unsigned M2 = ((64'd1 << K2) + 64'(SEG_W) - 64'd1) / SEG_W;

  localparam logic signed [AW-1:0] HALF_S = AW'(HALF_V);
  localparam logic [M1W-1:0]       M1_C   = M1W'(M1);
  localparam logic [M2W-1:0]       M2_C   = M2W'(M2);
  localparam logic [DW-1:0]        W_D    = DW'(SEG_W);
  localparam logic [IW:0]          SEGS_I = (IW + 1)'(TABLE_SEGMENTS);
  localparam logic [NW-1:0]        RND_N  = NW'(SEG_W / 2);
  localparam logic [SW-1:0]        ONE_S  = SW'(ONE_V);

  // sample table, constant logic
  logic [SW-1:0] rom [TABLE_SEGMENTS+1];
  for (genvar g = 0; g <= TABLE_SEGMENTS; g++) begin : g_rom
    localparam logic [15:0] SMP = afu_pkg::sig_sample(g, TABLE_SEGMENTS, FRAC_BITS);
    assign rom[g] = SMP[SW-1:0];
  end

  // stage 1: argument, end flags, offset into the table span
  logic signed [AW-1:0] arg;
  logic signed [AW-1:0] dsum;
  logic                 top1_q, bot1_q;
  logic [DW-1:0]        d1_q;

  assign arg  = (opcode_i == afu_pkg::OP_TANH) ? (AW'(operand_i) <<< 1) : AW'(operand_i);
  assign dsum = arg + HALF_S;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      top1_q <= (arg >= HALF_S);
      bot1_q <= (arg < -HALF_S);
      d1_q   <= dsum[DW-1:0];
    end
  end

  // stage 2: reciprocal product for the segment index
  logic [P1W-1:0] p1_q;
  logic [DW-1:0]  d2_q;
  logic           top2_q, bot2_q;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      p1_q   <= P1W'(d1_q) * P1W'(M1_C);
      d2_q   <= d1_q;
      top2_q <= top1_q;
      bot2_q <= bot1_q;
    end
  end

  // stage 3: index, offset within segment, table address
  logic [IW-1:0] idx;
  logic [DW-1:0] base;
  logic          past_end;
  logic [RW-1:0] addr3_q;
  logic [FW-1:0] frac3_q;
  logic          top3_q, bot3_q;

  assign idx      = p1_q[K1 +: IW];
  assign base     = DW'(idx) * W_D;
  assign past_end = ({1'b0, idx} >= SEGS_I);

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      frac3_q <= FW'(d2_q - base);
      addr3_q <= past_end ? '0 : RW'(idx);
      top3_q  <= top2_q | (~bot2_q & past_end);
      bot3_q  <= bot2_q;
    end
  end

  // stage 4: neighbouring samples
  logic [SW-1:0] s_lo, s_hi;
  logic [SW-1:0] lo4_q, diff4_q;
  logic [FW-1:0] frac4_q;
  logic          top4_q, bot4_q;

  assign s_lo = rom[addr3_q];
  assign s_hi = rom[addr3_q + 1'b1];

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      lo4_q   <= s_lo;
      diff4_q <= s_hi - s_lo;
      frac4_q <= frac3_q;
      top4_q  <= top3_q;
      bot4_q  <= bot3_q;
    end
  end

  // stage 5: slope times offset, plus half a segment for rounding
  logic [NW-1:0] num5_q;
  logic [SW-1:0] lo5_q;
  logic          top5_q, bot5_q;

  always_ff @(posedge clk_i) begin
    if (load_i[4]) begin
      num5_q <= NW'(diff4_q) * NW'(frac4_q) + RND_N;
      lo5_q  <= lo4_q;
      top5_q <= top4_q;
      bot5_q <= bot4_q;
    end
  end

  // stage 6: divide by segment width through the reciprocal
  logic [P2W-1:0] p2_q;
  logic [SW-1:0]  lo6_q;
  logic           top6_q, bot6_q;

  always_ff @(posedge clk_i) begin
    if (load_i[5]) begin
      p2_q   <= P2W'(num5_q) * P2W'(M2_C);
      lo6_q  <= lo5_q;
      top6_q <= top5_q;
      bot6_q <= bot5_q;
    end
  end

  always_comb begin
    if (top6_q) begin
      sig_o = ONE_S;
    end else if (bot6_q) begin
      sig_o = '0;
    end else begin
      sig_o = lo6_q + p2_q[K2 +: SW];
    end
  end

endmodule

`default_nettype wire

/* design/afu_deriv_pipe.sv */
// Derivative datapath: s*(1-s) or 1-t*t, rounded product and 16-bit clipping.
// Uses afu_pkg (op codes, widths); stage loads come from the top level.
`default_nettype none

module afu_deriv_pipe #(
  parameter int FRAC_BITS = afu_pkg::FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic [afu_pkg::PIPE_DEPTH-2:0]    load_i,
  input  wire logic [afu_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [afu_pkg::DATA_W-1:0] operand_i,
  output logic signed [afu_pkg::DATA_W-1:0]      res_o,
  output logic                                   sat_o
);

  localparam int ONE_V = 1 << FRAC_BITS;
  localparam int PW    = 34;

  localparam logic signed [16:0]   ONE_17 = 17'(ONE_V);
  localparam logic signed [PW-1:0] ONE_P  = PW'(ONE_V);
  localparam logic signed [PW-1:0] RND_P  = PW'(ONE_V / 2);
  localparam logic signed [PW-1:0] MAX_P  = PW'(32767);
  localparam logic signed [PW-1:0] MIN_P  = -PW'(32768);

  // stage 1: factors
  logic signed [16:0] x17;
  logic signed [15:0] a1_q;
  logic signed [16:0] b1_q;
  logic               sd1_q;
  logic               is_sd;

  assign is_sd = (opcode_i == afu_pkg::OP_SIG_D);
  assign x17   = 17'(operand_i);

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      a1_q  <= operand_i;
      b1_q  <= is_sd ? (ONE_17 - x17) : x17;
      sd1_q <= is_sd;
    end
  end

  // stage 2: product
  logic signed [PW-1:0] prod2_q;
  logic                 sd2_q;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      prod2_q <= PW'(a1_q) * PW'(b1_q);
      sd2_q   <= sd1_q;
    end
  end

  // stage 3: round half up, combine, clip
  logic signed [PW-1:0] rs;
  logic signed [PW-1:0] val;
  logic signed [15:0]   res3;
  logic                 sat3;

  assign rs  = (prod2_q + RND_P) >>> FRAC_BITS;
  assign val = sd2_q ? rs : (ONE_P - rs);

  always_comb begin
    sat3 = 1'b1;
    if (val > MAX_P) begin
      res3 = 16'sh7fff;
    end else if (val < MIN_P) begin
      res3 = 16'sh8000;
    end else begin
      res3 = val[15:0];
      sat3 = 1'b0;
    end
  end

  // stages 3..6: result waits for the sigmoid path
  logic signed [15:0] res_q [4];
  logic               sat_q [4];

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      res_q[0] <= res3;
      sat_q[0] <= sat3;
    end
    for (int k = 1; k < 4; k++) begin
      if (load_i[k+2]) begin
        res_q[k] <= res_q[k-1];
        sat_q[k] <= sat_q[k-1];
      end
    end
  end

  assign res_o = res_q[3];
  assign sat_o = sat_q[3];

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for activation_function_unit_core: directed and random beats,
// predicted results checked in order. Depends on afu_pkg and the core RTL only.
module tb_top;
  import afu_pkg::*;

  // Fixed-point constants for the default table and format
  localparam longint ONE   = longint'(1) << FRAC_BITS;
  localparam longint SPAN  = 8 * ONE;                      // sigmoid table covers +-8.0
  localparam longint SEG_W = (2 * SPAN) / TABLE_SEGMENTS;  // LSBs per table segment

  // Opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  // Cycles with no beat on either side, while work is pending, before giving up
  localparam int WATCHDOG = 3000;
  // Receiver hold-off used to back the pipeline up into the sender
  localparam int HOLD_CYCLES = 64;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] arg;
  } act_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } act_out_t;

  // DUT-facing signals; the driven inputs are all known from time zero
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          opcode_i    = '0;
  logic signed [DATA_W-1:0] operand_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] result_o;
  logic                     saturated_o;

  activation_function_unit_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .operand_i   (operand_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o),
    .saturated_o (saturated_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bench state
  longint    sig_rom [TABLE_SEGMENTS+1];  // sigmoid samples, built at time zero
  act_item_t beats_to_send [$];           // filled by the stimulus process
  act_out_t  results_due [$];             // predictions for accepted beats, oldest first
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        errors         = 0;
  int        quiet_cycles   = 0;
  bit        in_took        = 1'b0;       // input beat taken at the last rising edge
  bit        hold_arm       = 1'b0;
  bit        hold_used      = 1'b0;
  int        hold_left      = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sample i = round(ONE * sigmoid(-8 + 16*i/TABLE_SEGMENTS)). Built from
  // q = exp(-k*16/segs) in Q58; sigmoid(-x) = q/(1+q), the upper half mirrored.
  function automatic void build_sig_rom();
    logic [63:0]  unit;
    logic [63:0]  term;
    logic [63:0]  pos_sum;
    logic [63:0]  neg_sum;
    logic [63:0]  ratio;
    logic [63:0]  q;
    logic [63:0]  q_hi;
    logic [63:0]  den;
    logic [63:0]  num;
    logic [63:0]  v;
    logic [127:0] prod;
    int           half;
    unit    = 64'd1 << 58;
    term    = unit;
    pos_sum = unit;
    neg_sum = 64'd0;
    // exp(-16/segs) by its power series, alternating signs kept apart
    for (int k = 1; k <= 30; k++) begin
      term = (term * 64'd16) / (64'(TABLE_SEGMENTS) * 64'(k));
      if (k % 2 == 1) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    ratio = pos_sum - neg_sum;
    half  = TABLE_SEGMENTS / 2;
    q     = unit;
    for (int n = 0; n <= half; n++) begin
      q_hi = q >> 20;
      den  = (unit + q) >> 20;
      num  = q_hi << FRAC_BITS;
      v    = (64'd2 * num + den) / (64'd2 * den);
      sig_rom[half-n] = longint'(v);
      sig_rom[half+n] = ONE - longint'(v);
      prod = {64'd0, q} * {64'd0, ratio};
      q    = prod[121:58];
    end
  endfunction

  // Product back to Q5.10, rounding half up (arithmetic shift floors)
  function automatic longint round_q(longint v);
    return (v + ONE / 2) >>> FRAC_BITS;
  endfunction

  // Table sigmoid with linear interpolation; argument has no width limit
  function automatic longint sigmoid_q(longint x);
    longint d;
    longint lo;
    longint hi;
    int     idx;
    if (x >= SPAN) return ONE;
    if (x < -SPAN) return 0;
    d   = x + SPAN;
    idx = int'(d / SEG_W);
    if (idx >= TABLE_SEGMENTS) return ONE;
    lo = sig_rom[idx];
    hi = sig_rom[idx+1];
    // table rises monotonically, so the division never sees a negative
    return lo + ((hi - lo) * (d % SEG_W) + SEG_W / 2) / SEG_W;
  endfunction

  function automatic act_out_t activation_of(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] arg);
    longint   x;
    longint   r;
    act_out_t o;
    x = longint'(arg);
    case (op)
      OP_SIG:    r = sigmoid_q(x);
      OP_SIG_D:  r = round_q(x * (ONE - x));
      OP_RELU:   r = (x > 0) ? x : 0;
      OP_RELU_D: r = (x > 0) ? ONE : 0;
      OP_TANH:   r = 2 * sigmoid_q(2 * x) - ONE;
      OP_TANH_D: r = ONE - round_q(x * x);
      default:   r = 0;
    endcase
    o.sat = 1'b0;
    if (r > 32767) begin
      r     = 32767;
      o.sat = 1'b1;
    end else if (r < -32768) begin
      r     = -32768;
      o.sat = 1'b1;
    end
    o.value = DATA_W'(r);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: new beat at the falling edge once the previous one is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    act_item_t it;
    if (!in_valid_i || in_took) begin
      if (rst_ni && beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = beats_to_send.pop_front();
        opcode_i   <= it.op;
        operand_i  <= it.arg;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: random, or a long hold-off once armed so the pipe backs up
  always @(negedge clk_i) begin
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input beat, check each output beat in order
  // ---------------------------------------------------------------------------
  task automatic report_error(string what, act_out_t want, act_out_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected %0d sat %0b, got %0d sat %0b", $realtime, what,
               want.value, want.sat, got.value, got.sat);
    end
  endtask

  always @(posedge clk_i) begin
    act_out_t got;
    act_out_t want;
    if (rst_ni) begin
      got.value = result_o;
      got.sat   = saturated_o;
      if (out_fire) begin
        if (results_due.size() == 0) begin
          want = '0;
          report_error("unexpected beat", want, got);
        end else begin
          want = results_due.pop_front();
          if (got.value !== want.value) report_error("result", want, got);
          else if (got.sat !== want.sat) report_error("saturated", want, got);
        end
      end
      // checked before the push: a beat never leaves in the cycle it enters
      if (in_fire) results_due.push_back(activation_of(opcode_i, operand_i));
    end
    in_took <= in_fire;
  end

  // Watchdog: only counts while something is still owed
  always @(posedge clk_i) begin
    if (in_fire || out_fire ||
        (beats_to_send.size() == 0 && !in_valid_i && results_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_beat(logic [OP_W-1:0] op, int arg);
    act_item_t it;
    it.op  = op;
    it.arg = DATA_W'(arg);
    beats_to_send.push_back(it);
  endtask

  // Mostly the live ranges of each function, some full-width values, a few spare opcodes
  task automatic queue_random(int count);
    logic [OP_W-1:0] op;
    int              arg;
    int              pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) begin
        op = $urandom_range(1) ? OP_SPARE_B : OP_SPARE_A;
      end else begin
        op = OP_W'($urandom_range(int'(OP_TANH_D)));
      end
      pick = $urandom_range(9);
      if (pick < 3) begin
        arg = int'($urandom_range(65535));
      end else if (op == OP_SIG_D || op == OP_TANH_D) begin
        arg = int'($urandom_range(2200)) - 1100;  // activations, just past +-1.0
      end else begin
        arg = int'($urandom_range(18000)) - 9000;  // across the table and its ends
      end
      queue_beat(op, arg);
    end
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_valid_i || results_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    build_sig_rom();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: table ends, interpolation edges, saturating derivatives, spare opcodes
    queue_beat(OP_SIG, -32768);
    queue_beat(OP_SIG, -8193);
    queue_beat(OP_SIG, -8192);
    queue_beat(OP_SIG, -8191);
    queue_beat(OP_SIG, -1);
    queue_beat(OP_SIG, 0);
    queue_beat(OP_SIG, 8191);
    queue_beat(OP_SIG, 8192);
    queue_beat(OP_SIG, 32767);
    queue_beat(OP_SIG_D, 512);
    queue_beat(OP_SIG_D, 32767);
    queue_beat(OP_SIG_D, -32768);
    queue_beat(OP_RELU, 32767);
    queue_beat(OP_RELU, -32768);
    queue_beat(OP_RELU, 0);
    queue_beat(OP_RELU_D, 1);
    queue_beat(OP_RELU_D, 0);
    queue_beat(OP_RELU_D, -1);
    queue_beat(OP_TANH, 4095);
    queue_beat(OP_TANH, 4096);
    queue_beat(OP_TANH, -4096);
    queue_beat(OP_TANH, -4097);
    queue_beat(OP_TANH_D, 1024);
    queue_beat(OP_TANH_D, 32767);
    queue_beat(OP_SPARE_A, 32767);
    queue_beat(OP_SPARE_B, -32768);
    wait_drained();

    // Full rate, with one long receiver hold-off part way through
    queue_random(450);
    while (beats_to_send.size() > 380) @(posedge clk_i);
    hold_arm = 1'b1;
    wait_drained();

    // Sparse sender
    send_idle_pct  = 88;
    recv_stall_pct = 0;
    queue_random(450);
    wait_drained();

    // Slow receiver
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    queue_random(450);
    wait_drained();

    // Light jitter on both sides
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    queue_random(450);
    wait_drained();

    // let any stray beat surface before judging
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
